@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/lcdfb_pkg.sv @@
package lcdfb_pkg;

	localparam int unsigned ROW_BYTES   = 16;
	localparam int unsigned ROWS        = 64;
	localparam int unsigned PIX_COLS    = ROW_BYTES * 8;
	localparam int unsigned FRAME_DEPTH = ROWS * ROW_BYTES;
	localparam int unsigned ADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	localparam int unsigned COL_W       = $clog2(ROW_BYTES + 1);
	localparam int unsigned EXT_W       = 16;

	localparam logic [7:0] SYNC_CMD  = 8'hF8;
	localparam logic [7:0] SYNC_DATA = 8'hFA;
	localparam logic [7:0] CMD_EXT   = 8'h34;
	localparam logic [7:0] CMD_DISP  = 8'h36;
	localparam logic [7:0] CMD_BASIC = 8'h30;
	localparam logic [7:0] CMD_ADDR  = 8'h80;
	localparam logic [7:0] ROW_MASK  = 8'h1F;

	localparam logic [1:0] OP_DRAW  = 2'd0;
	localparam logic [1:0] OP_FLUSH = 2'd1;
	localparam logic [1:0] OP_CMD   = 2'd2;
	localparam logic [1:0] OP_DATA  = 2'd3;

	typedef logic [4:0] step_t;
	typedef logic [2:0] ld_t;
	typedef logic [2:0] em_t;
	typedef logic [1:0] ls_t;
	typedef logic [2:0] cond_t;
	typedef logic [3:0] flags_t;

	localparam ld_t LD_NONE   = 3'd0;
	localparam ld_t LD_VALUE  = 3'd1;
	localparam ld_t LD_MEM    = 3'd2;
	localparam ld_t LD_K34    = 3'd3;
	localparam ld_t LD_ROW_LO = 3'd4;
	localparam ld_t LD_ROW_HI = 3'd5;
	localparam ld_t LD_K36    = 3'd6;
	localparam ld_t LD_K30    = 3'd7;

	localparam em_t EM_NONE      = 3'd0;
	localparam em_t EM_SYNC_CMD  = 3'd1;
	localparam em_t EM_SYNC_DATA = 3'd2;
	localparam em_t EM_HI        = 3'd3;
	localparam em_t EM_LO        = 3'd4;

	localparam ls_t LS_NO      = 2'd0;
	localparam ls_t LS_YES     = 2'd1;
	localparam ls_t LS_ROW_END = 2'd2;

	localparam cond_t COND_NEXT         = 3'd0;
	localparam cond_t COND_ALWAYS       = 3'd1;
	localparam cond_t COND_DRAW_BAD     = 3'd2;
	localparam cond_t COND_ROW_BAD      = 3'd3;
	localparam cond_t COND_ROW_NZ       = 3'd4;
	localparam cond_t COND_MORE_COLS    = 3'd5;
	localparam cond_t COND_NOT_LAST_ROW = 3'd6;

	localparam flags_t FL_NONE    = 4'b0000;
	localparam flags_t FL_COL_CLR = 4'b0001;
	localparam flags_t FL_COL_INC = 4'b0010;
	localparam flags_t FL_DRAW_RD = 4'b0100;
	localparam flags_t FL_DRAW_WR = 4'b1000;

	localparam step_t S_DRAW_RD     = 5'd0;
	localparam step_t S_DRAW_WR     = 5'd1;
	localparam step_t S_CMD_SYNC    = 5'd2;
	localparam step_t S_ONE_HI      = 5'd3;
	localparam step_t S_ONE_LO      = 5'd4;
	localparam step_t S_DATA_SYNC   = 5'd5;
	localparam step_t S_FL_CHECK    = 5'd6;
	localparam step_t S_FL_ROW0     = 5'd7;
	localparam step_t S_EXT_SYNC    = 5'd8;
	localparam step_t S_EXT_HI      = 5'd9;
	localparam step_t S_EXT_LO      = 5'd10;
	localparam step_t S_ADDR_Y_SYNC = 5'd11;
	localparam step_t S_ADDR_Y_HI   = 5'd12;
	localparam step_t S_ADDR_Y_LO   = 5'd13;
	localparam step_t S_ADDR_X_SYNC = 5'd14;
	localparam step_t S_ADDR_X_HI   = 5'd15;
	localparam step_t S_ADDR_X_LO   = 5'd16;
	localparam step_t S_PIX_SYNC    = 5'd17;
	localparam step_t S_PIX_HI      = 5'd18;
	localparam step_t S_PIX_LO      = 5'd19;
	localparam step_t S_FL_TAIL     = 5'd20;
	localparam step_t S_DISP_SYNC   = 5'd21;
	localparam step_t S_DISP_HI     = 5'd22;
	localparam step_t S_DISP_LO     = 5'd23;
	localparam step_t S_BASIC_SYNC  = 5'd24;
	localparam step_t S_BASIC_HI    = 5'd25;
	localparam step_t S_BASIC_LO    = 5'd26;
	localparam step_t S_LAST        = S_BASIC_LO;

	typedef struct packed {
		ld_t   ld;
		em_t   em;
		ls_t   ls;
		cond_t cond;
		step_t target;
		logic  done;
		logic  col_clr;
		logic  col_inc;
		logic  draw_rd;
		logic  draw_wr;
	} ctl_t;

	typedef struct packed {
		ctl_t ctl;
		logic go;
	} step_cmd_t;

	typedef struct packed {
		logic draw_bad;
		logic row_bad;
		logic row_nz;
		logic more_cols;
		logic last_row;
		logic clearing;
		logic out_full;
	} status_t;

	function automatic ctl_t mk(input ld_t ld, input em_t em, input ls_t ls,
			input cond_t cond, input step_t target, input logic done,
			input flags_t fl);
		ctl_t c;
		c.ld      = ld;
		c.em      = em;
		c.ls      = ls;
		c.cond    = cond;
		c.target  = target;
		c.done    = done;
		c.col_clr = fl[0];
		c.col_inc = fl[1];
		c.draw_rd = fl[2];
		c.draw_wr = fl[3];
		return c;
	endfunction

	// The control program. A taken branch with done set ends the item.
	function automatic ctl_t ucode(input step_t pc);
		ctl_t c;
		case (pc)
			S_DRAW_RD:     c = mk(LD_NONE, EM_NONE, LS_NO, COND_DRAW_BAD, S_DRAW_RD,
					1'b1, FL_DRAW_RD);
			S_DRAW_WR:     c = mk(LD_NONE, EM_NONE, LS_NO, COND_ALWAYS, S_DRAW_RD,
					1'b1, FL_DRAW_RD | FL_DRAW_WR);
			S_CMD_SYNC:    c = mk(LD_VALUE, EM_SYNC_CMD, LS_NO, COND_NEXT, S_DRAW_RD,
					1'b0, FL_NONE);
			S_ONE_HI:      c = mk(LD_NONE, EM_HI, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0, FL_NONE);
			S_ONE_LO:      c = mk(LD_NONE, EM_LO, LS_YES, COND_ALWAYS, S_DRAW_RD, 1'b1,
					FL_NONE);
			S_DATA_SYNC:   c = mk(LD_VALUE, EM_SYNC_DATA, LS_NO, COND_ALWAYS, S_ONE_HI,
					1'b0, FL_NONE);
			S_FL_CHECK:    c = mk(LD_NONE, EM_NONE, LS_NO, COND_ROW_BAD, S_DRAW_RD, 1'b1,
					FL_NONE);
			S_FL_ROW0:     c = mk(LD_NONE, EM_NONE, LS_NO, COND_ROW_NZ, S_ADDR_Y_SYNC,
					1'b0, FL_NONE);
			S_EXT_SYNC:    c = mk(LD_K34, EM_SYNC_CMD, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0,
					FL_NONE);
			S_EXT_HI:      c = mk(LD_NONE, EM_HI, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0, FL_NONE);
			S_EXT_LO:      c = mk(LD_NONE, EM_LO, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0, FL_NONE);
			S_ADDR_Y_SYNC: c = mk(LD_ROW_LO, EM_SYNC_CMD, LS_NO, COND_NEXT, S_DRAW_RD,
					1'b0, FL_NONE);
			S_ADDR_Y_HI:   c = mk(LD_NONE, EM_HI, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0, FL_NONE);
			S_ADDR_Y_LO:   c = mk(LD_NONE, EM_LO, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0, FL_NONE);
			S_ADDR_X_SYNC: c = mk(LD_ROW_HI, EM_SYNC_CMD, LS_NO, COND_NEXT, S_DRAW_RD,
					1'b0, FL_COL_CLR);
			S_ADDR_X_HI:   c = mk(LD_NONE, EM_HI, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0, FL_NONE);
			S_ADDR_X_LO:   c = mk(LD_NONE, EM_LO, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0, FL_NONE);
			S_PIX_SYNC:    c = mk(LD_MEM, EM_SYNC_DATA, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0,
					FL_COL_INC);
			S_PIX_HI:      c = mk(LD_NONE, EM_HI, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0, FL_NONE);
			S_PIX_LO:      c = mk(LD_NONE, EM_LO, LS_ROW_END, COND_MORE_COLS, S_PIX_SYNC,
					1'b0, FL_NONE);
			S_FL_TAIL:     c = mk(LD_NONE, EM_NONE, LS_NO, COND_NOT_LAST_ROW, S_DRAW_RD,
					1'b1, FL_NONE);
			S_DISP_SYNC:   c = mk(LD_K36, EM_SYNC_CMD, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0,
					FL_NONE);
			S_DISP_HI:     c = mk(LD_NONE, EM_HI, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0, FL_NONE);
			S_DISP_LO:     c = mk(LD_NONE, EM_LO, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0, FL_NONE);
			S_BASIC_SYNC:  c = mk(LD_K30, EM_SYNC_CMD, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0,
					FL_NONE);
			S_BASIC_HI:    c = mk(LD_NONE, EM_HI, LS_NO, COND_NEXT, S_DRAW_RD, 1'b0, FL_NONE);
			S_BASIC_LO:    c = mk(LD_NONE, EM_LO, LS_YES, COND_ALWAYS, S_DRAW_RD, 1'b1,
					FL_NONE);
			default:       c = mk(LD_NONE, EM_NONE, LS_NO, COND_ALWAYS, S_DRAW_RD, 1'b1,
					FL_NONE);
		endcase
		return c;
	endfunction

	function automatic step_t entry(input logic [1:0] opcode);
		step_t s;
		case (opcode)
			OP_DRAW:  s = S_DRAW_RD;
			OP_FLUSH: s = S_FL_CHECK;
			OP_CMD:   s = S_CMD_SYNC;
			OP_DATA:  s = S_DATA_SYNC;
			default:  s = S_DRAW_RD;
		endcase
		return s;
	endfunction

endpackage

@@ hw/rtl/lcdfb_ram.sv @@
module lcdfb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/lcdfb_seq.sv @@
`include "assert_macros.svh"

module lcdfb_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           opcode,
	input  lcdfb_pkg::status_t   st,
	output logic                 in_ready,
	output lcdfb_pkg::step_cmd_t cmd
);

	logic               busy_q;
	lcdfb_pkg::step_t   pc_q;
	lcdfb_pkg::ctl_t    ctl;
	logic               taken;
	logic               advance;
	logic               accept;

	assign ctl      = lcdfb_pkg::ucode(pc_q);
	assign in_ready = !busy_q && !st.clearing;
	assign accept   = in_valid && in_ready;
	assign advance  = !((ctl.em != lcdfb_pkg::EM_NONE) && st.out_full);

	always_comb begin
		case (ctl.cond)
			lcdfb_pkg::COND_NEXT:         taken = 1'b0;
			lcdfb_pkg::COND_ALWAYS:       taken = 1'b1;
			lcdfb_pkg::COND_DRAW_BAD:     taken = st.draw_bad;
			lcdfb_pkg::COND_ROW_BAD:      taken = st.row_bad;
			lcdfb_pkg::COND_ROW_NZ:       taken = st.row_nz;
			lcdfb_pkg::COND_MORE_COLS:    taken = st.more_cols;
			lcdfb_pkg::COND_NOT_LAST_ROW: taken = !st.last_row;
			default:                      taken = 1'b0;
		endcase
	end

	assign cmd.ctl = ctl;
	assign cmd.go  = busy_q && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= lcdfb_pkg::S_DRAW_RD;
		end else if (accept) begin
			busy_q <= 1'b1;
			pc_q   <= lcdfb_pkg::entry(opcode);
		end else if (busy_q && advance) begin
			if (taken && ctl.done) begin
				busy_q <= 1'b0;
			end else if (taken) begin
				pc_q <= ctl.target;
			end else begin
				pc_q <= pc_q + 5'd1;
			end
		end
	end

	`ASSERT_ALWAYS(a_pc_in_program, !busy_q || (pc_q <= lcdfb_pkg::S_LAST),
		"sequencer ran past the end of the program")
	`ASSERT_NEXT(a_stall_holds, busy_q && !advance, busy_q && $stable(pc_q),
		"sequencer moved while its link byte was blocked")
	`ASSERT_NEXT(a_done_ends, busy_q && advance && taken && ctl.done, !busy_q,
		"item did not end on a finishing branch")

endmodule

@@ hw/rtl/lcdfb_dp.sv @@
`include "assert_macros.svh"

module lcdfb_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_accept,
	input  logic [7:0]           x,
	input  logic [7:0]           y,
	input  logic                 color,
	input  logic [7:0]           value,
	input  lcdfb_pkg::step_cmd_t cmd,
	input  logic                 out_ready,
	output lcdfb_pkg::status_t   st,
	output logic                 out_valid,
	output logic [7:0]           link_byte,
	output logic                 last
);

	logic [7:0]                     x_q;
	logic [7:0]                     y_q;
	logic                           color_q;
	logic [7:0]                     value_q;
	logic [7:0]                     byte_q;
	logic [lcdfb_pkg::COL_W-1:0]    col_q;
	logic                           clr_busy_q;
	logic [lcdfb_pkg::ADDR_W-1:0]   clr_addr_q;
	logic                           out_valid_q;
	logic [7:0]                     link_q;
	logic                           last_q;

	logic [lcdfb_pkg::EXT_W-1:0]    row_base;
	logic [lcdfb_pkg::EXT_W-1:0]    draw_ext;
	logic [lcdfb_pkg::EXT_W-1:0]    flush_ext;
	logic [lcdfb_pkg::ADDR_W-1:0]   draw_addr;
	logic [lcdfb_pkg::ADDR_W-1:0]   raddr;
	logic [lcdfb_pkg::ADDR_W-1:0]   waddr;
	logic [7:0]                     wdata;
	logic                           we;
	logic [7:0]                     rdata;
	logic [7:0]                     mask;
	logic [7:0]                     new_byte;
	logic [7:0]                     ld_byte;
	logic [7:0]                     em_byte;
	logic                           em_last;
	logic                           emit;

	assign row_base  = lcdfb_pkg::EXT_W'(y_q) * lcdfb_pkg::EXT_W'(lcdfb_pkg::ROW_BYTES);
	assign draw_ext  = row_base + lcdfb_pkg::EXT_W'(x_q >> 3);
	assign flush_ext = row_base + lcdfb_pkg::EXT_W'(col_q);
	assign draw_addr = draw_ext[lcdfb_pkg::ADDR_W-1:0];
	assign raddr     = cmd.ctl.draw_rd ? draw_addr : flush_ext[lcdfb_pkg::ADDR_W-1:0];

	assign mask     = 8'h80 >> x_q[2:0];
	assign new_byte = color_q ? (rdata | mask) : (rdata & ~mask);

	assign we    = clr_busy_q || (cmd.go && cmd.ctl.draw_wr);
	assign waddr = clr_busy_q ? clr_addr_q : draw_addr;
	assign wdata = clr_busy_q ? 8'h00 : new_byte;

	lcdfb_ram #(
		.WIDTH(8),
		.DEPTH(lcdfb_pkg::FRAME_DEPTH)
	) u_frame (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign st.draw_bad  = ({1'b0, x_q} >= 9'(lcdfb_pkg::PIX_COLS)) ||
			(y_q >= 8'(lcdfb_pkg::ROWS));
	assign st.row_bad   = y_q >= 8'(lcdfb_pkg::ROWS);
	assign st.row_nz    = y_q != 8'd0;
	assign st.more_cols = col_q != lcdfb_pkg::COL_W'(lcdfb_pkg::ROW_BYTES);
	assign st.last_row  = y_q == 8'(lcdfb_pkg::ROWS - 1);
	assign st.clearing  = clr_busy_q;
	assign st.out_full  = out_valid_q && !out_ready;

	always_comb begin
		case (cmd.ctl.ld)
			lcdfb_pkg::LD_VALUE:  ld_byte = value_q;
			lcdfb_pkg::LD_MEM:    ld_byte = rdata;
			lcdfb_pkg::LD_K34:    ld_byte = lcdfb_pkg::CMD_EXT;
			lcdfb_pkg::LD_ROW_LO: ld_byte = lcdfb_pkg::CMD_ADDR + (y_q & lcdfb_pkg::ROW_MASK);
			lcdfb_pkg::LD_ROW_HI: ld_byte = lcdfb_pkg::CMD_ADDR + ((y_q >> 5) << 3);
			lcdfb_pkg::LD_K36:    ld_byte = lcdfb_pkg::CMD_DISP;
			lcdfb_pkg::LD_K30:    ld_byte = lcdfb_pkg::CMD_BASIC;
			default:              ld_byte = byte_q;
		endcase
	end

	always_comb begin
		case (cmd.ctl.em)
			lcdfb_pkg::EM_SYNC_CMD:  em_byte = lcdfb_pkg::SYNC_CMD;
			lcdfb_pkg::EM_SYNC_DATA: em_byte = lcdfb_pkg::SYNC_DATA;
			lcdfb_pkg::EM_HI:        em_byte = {byte_q[7:4], 4'h0};
			lcdfb_pkg::EM_LO:        em_byte = {byte_q[3:0], 4'h0};
			default:                 em_byte = 8'h00;
		endcase
	end

	always_comb begin
		case (cmd.ctl.ls)
			lcdfb_pkg::LS_YES:     em_last = 1'b1;
			lcdfb_pkg::LS_ROW_END: em_last = !st.more_cols && !st.last_row;
			default:               em_last = 1'b0;
		endcase
	end

	assign emit = cmd.go && (cmd.ctl.em != lcdfb_pkg::EM_NONE);

	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q     <= x;
			y_q     <= y;
			color_q <= color;
			value_q <= value;
		end
		if (cmd.go) begin
			byte_q <= ld_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (cmd.go && cmd.ctl.col_clr) begin
			col_q <= '0;
		end else if (cmd.go && cmd.ctl.col_inc) begin
			col_q <= col_q + lcdfb_pkg::COL_W'(1);
		end
	end

	// The frame store is swept to zero once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == lcdfb_pkg::ADDR_W'(lcdfb_pkg::FRAME_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + lcdfb_pkg::ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			link_q <= em_byte;
			last_q <= em_last;
		end
	end

	assign out_valid = out_valid_q;
	assign link_byte = link_q;
	assign last      = last_q;

	`ASSERT_ALWAYS(a_no_draw_in_clear, !(clr_busy_q && cmd.go),
		"sequencer ran while the frame store was being cleared")
	`ASSERT_NEXT(a_clear_once, !clr_busy_q, !clr_busy_q,
		"frame store clear restarted without a reset")

endmodule

@@ hw/rtl/lcd_framebuffer_serial_flush.sv @@
// Channel   Dir  Transfer when            Payload
// s_axis    in   tvalid & tready          tuser: opcode; tdata: x, y, color, value
// m_axis    out  tvalid & tready          tdata: link_byte; tlast: last
//
// A draw in the frame rewrites one byte; a command or data byte sends three link
// bytes; a row flush sends address and pixel bytes, or none for a row outside the
// frame. The single output register moves one link byte per cycle while not stalled.
// After reset the 1024 frame bytes are cleared with s_axis_tready low. When
// m_axis_tready is low and a byte is pending, the program holds on its emitting step.
module lcd_framebuffer_serial_flush (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // x[7:0], y[15:8], color[16], value[24:17]
	input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // link_byte[7:0]
	output logic        m_axis_tlast
);

	lcdfb_pkg::status_t   st;
	lcdfb_pkg::step_cmd_t cmd;
	logic                 in_accept;

	assign in_accept = s_axis_tvalid && s_axis_tready;

	lcdfb_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.opcode  (s_axis_tuser),
		.st      (st),
		.in_ready(s_axis_tready),
		.cmd     (cmd)
	);

	lcdfb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_accept(in_accept),
		.x        (s_axis_tdata[7:0]),
		.y        (s_axis_tdata[15:8]),
		.color    (s_axis_tdata[16]),
		.value    (s_axis_tdata[24:17]),
		.cmd      (cmd),
		.out_ready(m_axis_tready),
		.st       (st),
		.out_valid(m_axis_tvalid),
		.link_byte(m_axis_tdata),
		.last     (m_axis_tlast)
	);

endmodule

@@ tb/sv/lcd_framebuffer_serial_flush_checker.sv @@
`timescale 1ns / 1ps

module lcd_framebuffer_serial_flush_checker
	import lcdfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [7:0] link_byte;
		logic       last;
	} link_t;

	logic [7:0] pixels [FRAME_DEPTH];
	link_t      link_expect [$];
	link_t      want;
	int         k;

	task automatic report_mismatch(input string what);
		$display("%0t ns: link mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic queue_framed(input logic [7:0] sync, input logic [7:0] b, input logic fin);
		link_expect.push_back('{sync, 1'b0});
		link_expect.push_back('{b & 8'hF0, 1'b0});
		link_expect.push_back('{{b[3:0], 4'h0}, fin});
	endtask

	task automatic predict_item(input logic [1:0] op, input logic [31:0] d);
		logic [7:0] px;
		logic [7:0] py;
		logic [7:0] val;
		logic       col;
		int         idx;
		int         j;
		px  = d[7:0];
		py  = d[15:8];
		col = d[16];
		val = d[24:17];
		case (op)
			OP_DRAW: begin
				if (px < PIX_COLS && py < ROWS) begin
					idx = int'(py) * ROW_BYTES + int'(px >> 3);
					if (col)
						pixels[idx] = pixels[idx] | (8'h80 >> px[2:0]);
					else
						pixels[idx] = pixels[idx] & ~(8'h80 >> px[2:0]);
				end
			end
			OP_FLUSH: begin
				if (py < ROWS) begin
					if (py == 0)
						queue_framed(SYNC_CMD, CMD_EXT, 1'b0);
					queue_framed(SYNC_CMD, CMD_ADDR + (py & ROW_MASK), 1'b0);
					queue_framed(SYNC_CMD, CMD_ADDR + ((py >> 5) << 3), 1'b0);
					for (j = 0; j < ROW_BYTES; j++)
						queue_framed(SYNC_DATA, pixels[int'(py) * ROW_BYTES + j],
								(j == ROW_BYTES - 1) && (py != ROWS - 1));
					if (py == ROWS - 1) begin
						queue_framed(SYNC_CMD, CMD_DISP, 1'b0);
						queue_framed(SYNC_CMD, CMD_BASIC, 1'b1);
					end
				end
			end
			OP_CMD: queue_framed(SYNC_CMD, val, 1'b1);
			default: queue_framed(SYNC_DATA, val, 1'b1);
		endcase
	endtask

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (k = 0; k < FRAME_DEPTH; k++)
				pixels[k] = 8'h00;
			link_expect.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_item(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (link_expect.size() == 0) begin
					report_mismatch($sformatf("byte %02h with nothing expected", m_axis_tdata));
				end else begin
					want = link_expect.pop_front();
					if (m_axis_tdata !== want.link_byte)
						report_mismatch($sformatf("link_byte got %02h expected %02h",
								m_axis_tdata, want.link_byte));
					if (m_axis_tlast !== want.last)
						report_mismatch($sformatf("last got %b expected %b",
								m_axis_tlast, want.last));
				end
			end
		end
		outstanding = link_expect.size();
	end

endmodule

@@ tb/sv/lcd_framebuffer_serial_flush_test.sv @@
`timescale 1ns / 1ps

module lcd_framebuffer_serial_flush_test;
	import lcdfb_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	int          mismatches;
	int          outstanding;
	bit          idling;
	int          hold_len;
	logic [7:0]  hot_rows [4];

	always #1 clk = ~clk;

	lcd_framebuffer_serial_flush DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	lcd_framebuffer_serial_flush_checker link_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	task automatic send_item(input logic [1:0] op, input logic [7:0] px, input logic [7:0] py,
			input logic col, input logic [7:0] val);
		s_axis_tuser  = op;
		s_axis_tdata  = {7'd0, val, col, py, px};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		if (idling && $urandom_range(0, 2) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	task automatic drain_links();
		s_axis_tvalid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic send_random();
		int         pick;
		logic [7:0] px;
		logic [7:0] py;
		pick = $urandom_range(0, 99);
		px = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(0, PIX_COLS - 1));
		case ($urandom_range(0, 19))
			0, 1, 2: py = 8'($urandom_range(0, 255));
			3, 4:    py = 8'($urandom_range(0, ROWS - 1));
			default: py = hot_rows[$urandom_range(0, 3)];
		endcase
		if (pick < 55)
			send_item(OP_DRAW, px, py, 1'($urandom), 8'($urandom));
		else if (pick < 75)
			send_item(OP_FLUSH, 8'($urandom), py, 1'($urandom), 8'($urandom));
		else if (pick < 87)
			send_item(OP_CMD, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
		else
			send_item(OP_DATA, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
	endtask

	initial begin
		m_axis_tready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_len != 0) begin
				m_axis_tready = 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
			end else if (idling && $urandom_range(0, 2) == 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end else begin
				m_axis_tready = 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
	end

	initial begin
		#2000000;
		$display("lcd_framebuffer_serial_flush_test: FAIL");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_DRAW;
		idling        = 1'b1;
		hold_len      = 0;
		hot_rows[0]   = 8'd0;
		hot_rows[1]   = 8'(ROWS - 1);
		hot_rows[2]   = 8'($urandom_range(1, ROWS - 2));
		hot_rows[3]   = 8'($urandom_range(1, ROWS - 2));
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_item(OP_FLUSH, 8'h5A, 8'd0, 1'b1, 8'hC3);
		send_item(OP_DRAW, 8'd0, 8'd0, 1'b1, 8'hFF);
		send_item(OP_DRAW, 8'd127, 8'd0, 1'b1, 8'h00);
		send_item(OP_DRAW, 8'd7, 8'd0, 1'b1, 8'h55);
		send_item(OP_DRAW, 8'd8, 8'd0, 1'b1, 8'hAA);
		send_item(OP_DRAW, 8'd0, 8'd63, 1'b1, 8'h12);
		send_item(OP_DRAW, 8'd127, 8'd63, 1'b1, 8'h34);
		send_item(OP_DRAW, 8'd64, 8'd63, 1'b1, 8'h00);
		send_item(OP_DRAW, 8'd127, 8'd0, 1'b0, 8'hFF);
		send_item(OP_DRAW, 8'd128, 8'd0, 1'b1, 8'hFF);
		send_item(OP_DRAW, 8'd255, 8'd32, 1'b1, 8'hFF);
		send_item(OP_DRAW, 8'd5, 8'd64, 1'b1, 8'hFF);
		send_item(OP_DRAW, 8'd5, 8'd255, 1'b1, 8'hFF);
		send_item(OP_FLUSH, 8'hFF, 8'd0, 1'b0, 8'h00);
		send_item(OP_FLUSH, 8'h00, 8'd63, 1'b1, 8'hFF);
		send_item(OP_FLUSH, 8'h00, 8'd31, 1'b0, 8'h00);
		send_item(OP_FLUSH, 8'h00, 8'd32, 1'b0, 8'h00);
		send_item(OP_FLUSH, 8'h00, 8'd64, 1'b0, 8'h00);
		send_item(OP_FLUSH, 8'h00, 8'd255, 1'b0, 8'h00);
		send_item(OP_CMD, 8'hFF, 8'hFF, 1'b1, 8'h00);
		send_item(OP_CMD, 8'h00, 8'h00, 1'b0, 8'hFF);
		send_item(OP_DATA, 8'hAA, 8'h55, 1'b1, 8'h00);
		send_item(OP_DATA, 8'h55, 8'hAA, 1'b0, 8'hFF);
		send_item(OP_DATA, 8'h00, 8'h00, 1'b0, 8'hA5);

		hold_len = 400;
		send_item(OP_FLUSH, 8'h00, hot_rows[2], 1'b0, 8'h00);
		send_item(OP_FLUSH, 8'h00, 8'd63, 1'b0, 8'h00);
		send_item(OP_CMD, 8'h00, 8'h00, 1'b0, 8'h3C);
		send_item(OP_FLUSH, 8'h00, 8'd0, 1'b0, 8'h00);
		send_item(OP_DATA, 8'h00, 8'h00, 1'b0, 8'hC3);
		send_item(OP_FLUSH, 8'h00, hot_rows[3], 1'b0, 8'h00);
		drain_links();

		repeat (55) send_random();
		idling = 1'b0;
		repeat (25) send_random();
		drain_links();
		repeat (80) @(negedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("lcd_framebuffer_serial_flush_test: PASS");
		else
			$display("lcd_framebuffer_serial_flush_test: FAIL");
		$finish;
	end

endmodule
